>>> rtl/core/cht_pkg.sv
// Shared types and constants for the completion head tracker.
// No dependencies; imported by the table memory and the top level.
package cht_pkg;

  // Sequence number and field widths
  localparam int unsigned SeqW     = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned UsedOutW = 6;

  // Largest sequence number; the head never moves past it
  localparam logic [SeqW-1:0] SeqMax = {SeqW{1'b1}};

  // Operation codes carried in the low bits of the input item
  typedef enum logic [ModeW-1:0] {
    MODE_QUERY   = 2'd0,
    MODE_MARK    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

endpackage

>>> rtl/core/cht_table_mem.sv
// Out-of-order entry store: one write port, one read port, registered read data.
// Depends on cht_pkg for the sequence number width.
module cht_table_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [cht_pkg::SeqW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [cht_pkg::SeqW-1:0] rdata_o
);
  import cht_pkg::*;

  logic [SeqW-1:0] mem_q [Depth];
  logic [SeqW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/completion_head_tracker.sv
// Top level of the completion head tracker: stream ports, sequencer, result register.
// Depends on cht_pkg and cht_table_mem.
//
// Tracks finished sequence numbers as a cumulative head plus a table of up to
// TABLE_DEPTH finished numbers above the head. Each input item queries, marks or
// restarts, and yields one result item. Items are worked one at a time; the input
// is taken again as soon as the result is in the output register. A restart or an
// item whose number is at or below the head skips the table scan. Any other item
// scans the table through the single read port of the entry memory, one entry a
// cycle. A mark that fills the gap above the head then rescans the table for each
// entry absorbed into the head.
module completion_head_tracker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item: [1:0] mode, [33:2] sequence_req, [39:34] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Result item: [0] was_finished, [32:1] head_value, [38:33] table_used,
  // [39] marker_lost
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);
  import cht_pkg::*;

  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_MOVE_RD = 5'b00100,
    ST_MOVE_WR = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Architectural state
  logic [SeqW-1:0]  head_q, head_d;
  logic [UsedW-1:0] used_q, used_d;

  // Per-item control
  logic             mark_q, mark_d;
  logic             absorb_q, absorb_d;
  logic [UsedW-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             was_q, was_d;
  logic             lost_q, lost_d;
  logic             out_valid_q, out_valid_d;

  // Per-item payload
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [SeqW-1:0]  target_q, target_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic [AddrW-1:0] hit_idx_q, hit_idx_d;
  logic             out_was_q, out_lost_q;
  logic [SeqW-1:0]  out_head_q;
  logic [UsedOutW-1:0] out_used_q;
  logic             out_load;

  // Memory port
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [SeqW-1:0]  mem_wdata, mem_rdata;

  // Decoded input and helpers
  mode_e            mode_in;
  logic [SeqW-1:0]  seq_in;
  logic             in_mark, in_restart;
  logic             rd_en, hit, miss;
  logic [UsedW-1:0] used_m1;
  logic [UsedW+UsedOutW-1:0] used_ext;

  assign mode_in = mode_e'(s_axis_tdata[ModeW-1:0]);
  assign seq_in  = s_axis_tdata[ModeW+SeqW-1:ModeW];
  assign used_m1 = used_q - UsedW'(1);
  assign used_ext = (UsedW + UsedOutW)'(used_q);

  // Decode the operation; an unused code acts as a query
  always_comb begin
    in_mark    = 1'b0;
    in_restart = 1'b0;
    case (mode_in)
      MODE_MARK:    in_mark = 1'b1;
      MODE_RESTART: in_restart = 1'b1;
      MODE_QUERY:   in_mark = 1'b0;
      default:      in_mark = 1'b0;
    endcase
  end

  // Scan pipeline: issue a read per cycle, compare the returned data in the next cycle
  assign rd_en = (idx_q < used_q);
  assign hit   = pend_q && (mem_rdata == target_q);
  assign miss  = !rd_en && !pend_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    used_d    = used_q;
    mark_d    = mark_q;
    absorb_d  = absorb_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    was_d     = was_q;
    lost_d    = lost_q;
    seq_d     = seq_q;
    target_d  = target_q;
    pidx_d    = pidx_q;
    hit_idx_d = hit_idx_q;
    mem_we    = 1'b0;
    mem_waddr = used_q[AddrW-1:0];
    mem_wdata = seq_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AddrW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mark_d   = in_mark;
          seq_d    = seq_in;
          was_d    = 1'b0;
          lost_d   = 1'b0;
          absorb_d = 1'b0;
          if (in_restart) begin
            head_d  = seq_in;
            used_d  = '0;
            state_d = ST_DONE;
          end else if (seq_in <= head_q) begin
            was_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            target_d = seq_in;
            idx_d    = '0;
            state_d  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        mem_re = rd_en;
        if (rd_en) begin
          idx_d  = idx_q + UsedW'(1);
          pend_d = 1'b1;
        end
        pidx_d = idx_q[AddrW-1:0];
        if (hit) begin
          pend_d = 1'b0;
          if (absorb_q) begin
            hit_idx_d = pidx_q;
            state_d   = ST_MOVE_RD;
          end else begin
            was_d   = 1'b1;
            state_d = ST_DONE;
          end
        end else if (miss) begin
          if (absorb_q || !mark_q) begin
            state_d = ST_DONE;
          end else if (used_q == UsedW'(TABLE_DEPTH)) begin
            // Table full: drop the mark
            lost_d  = 1'b1;
            state_d = ST_DONE;
          end else if (seq_q == (head_q + 32'd1)) begin
            // Mark closes the gap: move the head, then absorb followers
            head_d = seq_q;
            if (seq_q == SeqMax) begin
              state_d = ST_DONE;
            end else begin
              absorb_d = 1'b1;
              target_d = seq_q + 32'd1;
              idx_d    = '0;
            end
          end else begin
            // Store the out-of-order number at the end of the table
            mem_we  = 1'b1;
            used_d  = used_q + UsedW'(1);
            state_d = ST_DONE;
          end
        end
      end

      ST_MOVE_RD: begin
        // Fetch the last entry to fill the hole left by the absorbed one
        mem_re    = 1'b1;
        mem_raddr = used_m1[AddrW-1:0];
        state_d   = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = mem_rdata;
        used_d    = used_m1;
        head_d    = head_q + 32'd1;
        if (head_q == (SeqMax - 32'd1)) begin
          state_d = ST_DONE;
        end else begin
          target_d = head_q + 32'd2;
          idx_d    = '0;
          state_d  = ST_SCAN;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: drop on handshake, set on load
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      used_q      <= '0;
      mark_q      <= 1'b0;
      absorb_q    <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      was_q       <= 1'b0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      used_q      <= used_d;
      mark_q      <= mark_d;
      absorb_q    <= absorb_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      was_q       <= was_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    target_q  <= target_d;
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    if (out_load) begin
      out_was_q  <= was_q;
      out_lost_q <= lost_q;
      out_head_q <= head_q;
      out_used_q <= used_ext[UsedOutW-1:0];
    end
  end

  cht_table_mem #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_table_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lost_q, out_used_q, out_head_q, out_was_q};

endmodule
